/* hdl/hex_number_formatter_core_defines.svh */
// ----------------------------------------------------------------------------
// Hex number formatter assertion macros
// Shared concurrent assertion forms, sampled on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HEX_NUMBER_FORMATTER_CORE_DEFINES_SVH
`define HEX_NUMBER_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication
`define HNF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hnf assertion failed");

// Next-cycle implication
`define HNF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hnf assertion failed");

`endif

/* hdl/hnf_pkg.sv */
// ----------------------------------------------------------------------------
// Hex number formatter package
// Types, widths, character codes and helpers shared by the formatter modules.
// ----------------------------------------------------------------------------
package hnf_pkg;

  // Default parameter values
  localparam int unsigned VALUE_BITS_DEF    = 32;
  localparam int unsigned MAX_OUT_CHARS_DEF = 64;

  // Field widths
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned FW_W    = 7;
  localparam int unsigned PREC_W  = 6;
  localparam int unsigned NIB_MAX = VAL_W / 4;
  localparam int unsigned NAT_W   = $clog2(NIB_MAX + 1);
  localparam int unsigned NIB_IDX_W = $clog2(NIB_MAX);
  localparam int unsigned POS_W   = 8;
  localparam int unsigned CHAR_W  = 8;

  // Stream payload widths
  localparam int unsigned IN_FIELDS_W = VAL_W + FW_W + PREC_W + 5;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = CHAR_W;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_X_LO  = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_X_UP  = 8'h58;
  localparam logic [CHAR_W-1:0] CHAR_A_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_A_UP  = 8'h41;

  // One format request
  typedef struct packed {
    logic              upper_case;
    logic              alt_prefix;
    logic              zero_pad;
    logic              left_justify;
    logic              precision_given;
    logic [PREC_W-1:0] digit_precision;
    logic [FW_W-1:0]   field_width;
    logic [VAL_W-1:0]  value;
  } spec_t;

  // Layout of the output text: segment ends as character positions
  typedef struct packed {
    logic [VAL_W-1:0] value;      // masked value
    logic [NAT_W-1:0] nat;        // significant digits
    logic             upper;
    logic [POS_W-1:0] sp_end;     // end of leading spaces
    logic [POS_W-1:0] pre_end;    // end of 0x prefix
    logic [POS_W-1:0] zero_end;   // end of leading zeros
    logic [POS_W-1:0] dig_end;    // end of digits
    logic [POS_W-1:0] len;        // characters emitted after truncation
  } plan_t;

  // ASCII code of one hex digit
  function automatic logic [CHAR_W-1:0] hex_ascii(input logic [3:0] nib, input logic upper);
    logic [CHAR_W-1:0] nib_e;
    nib_e = {4'h0, nib};
    if (nib < 4'd10) begin
      return CHAR_ZERO + nib_e;
    end
    return (upper ? CHAR_A_UP : CHAR_A_LO) + nib_e - 8'd10;
  endfunction

endpackage

/* hdl/hnf_plan.sv */
// ----------------------------------------------------------------------------
// Hex number formatter layout planner
// Counts digits, padding and prefix and derives the segment boundaries.
// ----------------------------------------------------------------------------
module hnf_plan #(
  parameter int unsigned VALUE_BITS    = hnf_pkg::VALUE_BITS_DEF,
  parameter int unsigned MAX_OUT_CHARS = hnf_pkg::MAX_OUT_CHARS_DEF
) (
  input  hnf_pkg::spec_t spec_i,
  output hnf_pkg::plan_t plan_o
);
  import hnf_pkg::*;

  localparam logic [VAL_W-1:0] VMASK = (VALUE_BITS >= VAL_W) ? {VAL_W{1'b1}}
                                     : VAL_W'((64'd1 << VALUE_BITS) - 64'd1);
  localparam logic [POS_W-1:0] MAX_LEN = POS_W'(MAX_OUT_CHARS);

  logic [VAL_W-1:0] vm;
  logic [NAT_W-1:0] nat_raw;
  logic [NAT_W-1:0] nat;
  logic [POS_W-1:0] nd;
  logic [POS_W-1:0] pre;
  logic [POS_W-1:0] body;
  logic [POS_W-1:0] width_e;
  logic [POS_W-1:0] pad;
  logic [POS_W-1:0] zeros;
  logic [POS_W-1:0] total;
  logic             zmode;

  assign vm = spec_i.value & VMASK;

  // Find the highest nonzero nibble
  always_comb begin
    nat_raw = '0;
    for (int i = 0; i < NIB_MAX; i++) begin
      if (vm[i*4 +: 4] != 4'h0) begin
        nat_raw = NAT_W'(i + 1);
      end
    end
  end

  // Digit, prefix and padding counts
  always_comb begin
    if (vm == '0) begin
      nat = (spec_i.precision_given && spec_i.digit_precision == '0) ? NAT_W'(0) : NAT_W'(1);
    end else begin
      nat = nat_raw;
    end
    nd = (spec_i.precision_given && POS_W'(spec_i.digit_precision) > POS_W'(nat))
         ? POS_W'(spec_i.digit_precision) : POS_W'(nat);
    pre     = (spec_i.alt_prefix && vm != '0) ? POS_W'(2) : POS_W'(0);
    body    = pre + nd;
    width_e = POS_W'(spec_i.field_width);
    pad     = (width_e > body) ? width_e - body : '0;
    zmode   = spec_i.zero_pad && !spec_i.precision_given && !spec_i.left_justify;
    zeros   = (zmode ? pad : POS_W'(0)) + (nd - POS_W'(nat));
  end

  // Segment boundaries and truncated length
  always_comb begin
    plan_o.value    = vm;
    plan_o.nat      = nat;
    plan_o.upper    = spec_i.upper_case;
    plan_o.sp_end   = (!spec_i.left_justify && !zmode) ? pad : POS_W'(0);
    plan_o.pre_end  = plan_o.sp_end + pre;
    plan_o.zero_end = plan_o.pre_end + zeros;
    plan_o.dig_end  = plan_o.zero_end + POS_W'(nat);
    total           = plan_o.dig_end + (spec_i.left_justify ? pad : POS_W'(0));
    plan_o.len      = (total > MAX_LEN) ? MAX_LEN : total;
  end

endmodule

/* hdl/hnf_char.sv */
// ----------------------------------------------------------------------------
// Hex number formatter character select
// Picks the ASCII character at one position of the planned text.
// ----------------------------------------------------------------------------
module hnf_char (
  input  hnf_pkg::plan_t                     plan_i,
  input  logic [hnf_pkg::POS_W-1:0]          pos_i,
  output logic [hnf_pkg::CHAR_W-1:0]         char_o
);
  import hnf_pkg::*;

  logic [POS_W-1:0]     k;
  logic [NIB_IDX_W-1:0] idx;
  logic [3:0]           nib;

  // Digit index counted from the most significant digit
  assign k   = pos_i - plan_i.zero_end;
  assign idx = NIB_IDX_W'(plan_i.nat - NAT_W'(1) - NAT_W'(k));
  assign nib = plan_i.value[idx*4 +: 4];

  // Select by segment
  always_comb begin
    if (pos_i < plan_i.sp_end) begin
      char_o = CHAR_SPACE;
    end else if (pos_i < plan_i.pre_end) begin
      char_o = (pos_i == plan_i.sp_end) ? CHAR_ZERO : (plan_i.upper ? CHAR_X_UP : CHAR_X_LO);
    end else if (pos_i < plan_i.zero_end) begin
      char_o = CHAR_ZERO;
    end else if (pos_i < plan_i.dig_end) begin
      char_o = hex_ascii(nib, plan_i.upper);
    end else begin
      char_o = CHAR_SPACE;
    end
  end

endmodule

/* hdl/hex_number_formatter_core.sv */
// ----------------------------------------------------------------------------
// Hex number formatter core
// printf-style %x / %X conversion streamed out one ASCII character per item.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one conversion request per item: the value and its format
//   spec. m_axis returns the formatted text, one character per item, with
//   tlast on the final character. A conversion with no text (value 0, given
//   precision 0, width 0) produces no output item at all.
//   An accepted request waits in the request register while its characters
//   move to the output register, until all of them (at most MAX_OUT_CHARS)
//   have moved on; the output register takes one character per cycle while
//   the receiver does not stall. The next request is accepted in the cycle
//   that its last character moves to the output register, so conversions
//   follow each other without gaps.
//   Reset clears the request and output valid flags and the position count.
//   When the receiver stalls, the output register holds its character and
//   the request register holds its position until the character is taken.
// ----------------------------------------------------------------------------
`include "hex_number_formatter_core_defines.svh"

module hex_number_formatter_core #(
  parameter int unsigned VALUE_BITS    = hnf_pkg::VALUE_BITS_DEF,
  parameter int unsigned MAX_OUT_CHARS = hnf_pkg::MAX_OUT_CHARS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // value, field_width, digit_precision, precision_given, left_justify,
  // zero_pad, alt_prefix, upper_case (lowest bit up), zero filled
  input  logic [hnf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // char_code
  output logic [hnf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast
);
  import hnf_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_OUT_CHARS);

  spec_t             spec_d;
  spec_t             spec_q;
  logic              item_vld_q;
  logic [CNT_W-1:0]  cnt_q;
  plan_t             plan;
  logic [POS_W-1:0]  pos;
  logic [CHAR_W-1:0] ch;
  logic              out_vld_q;
  logic [CHAR_W-1:0] char_q;
  logic              last_q;
  logic              out_free;
  logic              item_empty;
  logic              emit;
  logic              emit_last;
  logic              item_done;
  logic              in_acc;

  // Unpack the request fields
  assign spec_d = spec_t'(s_axis_tdata[IN_FIELDS_W-1:0]);

  hnf_plan #(
    .VALUE_BITS    (VALUE_BITS),
    .MAX_OUT_CHARS (MAX_OUT_CHARS)
  ) u_plan (
    .spec_i (spec_q),
    .plan_o (plan)
  );

  assign pos = POS_W'(cnt_q);

  hnf_char u_char (
    .plan_i (plan),
    .pos_i  (pos),
    .char_o (ch)
  );

  // Handshake and emission control
  assign out_free   = !out_vld_q || m_axis_tready;
  assign item_empty = (plan.len == '0);
  assign emit       = item_vld_q && !item_empty && out_free;
  assign emit_last  = (POS_W'(pos + POS_W'(1)) == plan.len);
  assign item_done  = item_vld_q && (item_empty || (emit && emit_last));
  assign in_acc     = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = !item_vld_q || item_done;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = char_q;
  assign m_axis_tlast  = last_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      cnt_q      <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        item_vld_q <= 1'b1;
      end else if (item_done) begin
        item_vld_q <= 1'b0;
      end
      if (item_done) begin
        cnt_q <= '0;
      end else if (emit) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      spec_q <= spec_d;
    end
    if (emit) begin
      char_q <= ch;
      last_q <= emit_last;
    end
  end

  // Checks
  `HNF_ASSERT_IMP(a_pos_in_range, item_vld_q && !item_empty, pos < plan.len)
  `HNF_ASSERT_IMP(a_emit_into_free, emit, !out_vld_q || m_axis_tready)
  `HNF_ASSERT_NXT(a_last_resets_pos, emit && emit_last, cnt_q == '0 && m_axis_tlast)

endmodule
